// ===== hw/rtl/kxb64_pkg.sv =====
package kxb64_pkg;

   // Field widths fixed by the register and stream formats
   localparam int KEY_LEN_W  = 5;
   localparam int KEY_WORD_W = 64;
   localparam int BYTE_W     = 8;
   localparam int CHARS_MAX  = 4;

   localparam logic [BYTE_W-1:0] PAD_CHAR = 8'h3D;  // '='

   typedef enum logic [1:0] {
      CSR_KEY_LENGTH = 2'd0,
      CSR_KEY_LOW    = 2'd1,
      CSR_KEY_HIGH   = 2'd2
   } csr_index_type;

   // Bytes already taken into the current 3-byte group
   typedef enum logic [1:0] {
      PH_0 = 2'd0,
      PH_1 = 2'd1,
      PH_2 = 2'd2
   } phase_type;

   // Characters produced by one byte, emitted chars[0] first
   typedef struct packed {
      logic [CHARS_MAX-1:0][BYTE_W-1:0] chars;
      logic [1:0]                       last_idx;
      logic                             eom;
   } bundle_type;

   // Standard base64 alphabet
   function automatic logic [BYTE_W-1:0] b64_char(input logic [5:0] v);
      logic [BYTE_W-1:0] v8;
      logic [BYTE_W-1:0] ch;
      v8 = {2'b00, v};
      if (v < 6'd26) begin
         ch = 8'h41 + v8;
      end else if (v < 6'd52) begin
         ch = 8'h61 + v8 - 8'd26;
      end else if (v < 6'd62) begin
         ch = 8'h30 + v8 - 8'd52;
      end else if (v == 6'd62) begin
         ch = 8'h2B;
      end else begin
         ch = 8'h2F;
      end
      return ch;
   endfunction

endpackage

// ===== hw/rtl/keyed_xor_base64_encoder.sv =====
// Repeating-key XOR followed by streaming base64 encoding.
// Request channel (req_valid / req_stall): one message byte per transaction,
// req_end_of_message marks the final byte of a message.
// Response channel (rsp_valid / rsp_stall): one ASCII character per
// transaction; rsp_last_char flags the final character of a message,
// padding '=' included.
// Config port (csr_wr_en / csr_index / csr_wdata): 0 key length, 1 key
// bytes 0..7, 2 key bytes 8..15. Write only while the block is idle.
// Data path: an accepted byte lands in the input register, is encoded
// into the character register once that register is free, and its first
// character is then offered on the response port.
// Throughput: one character per cycle while rsp_stall is low; a byte
// yields 1 or 2 characters mid-message, up to 4 on the last byte, about
// 1.33 on average. The single character output port sets this.
// Reset (synchronous): key length 1, key zero, position and group phase
// zero, both stages empty.
// Stalls: a stalled response holds its character; the input register
// keeps taking one byte, then req_stall rises until the character
// register drains.
module keyed_xor_base64_encoder #(
   parameter int KEY_MAX = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_last_char,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   localparam int POS_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
   localparam logic [kxb64_pkg::KEY_LEN_W-1:0] KEY_MAX_L = kxb64_pkg::KEY_LEN_W'(KEY_MAX);

   // Configuration
   logic [kxb64_pkg::KEY_LEN_W-1:0] key_len_ff;
   logic [KEY_MAX-1:0][7:0]         key_ff;

   // Encoder state
   logic [POS_W-1:0]     pos_ff, pos_in;
   kxb64_pkg::phase_type phase_ff, phase_in;
   logic [3:0]           left_ff, left_in;

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eom_ff;

   // Character register
   logic                  bund_valid_ff, bund_valid_in;
   kxb64_pkg::bundle_type bund_ff, bund_in;
   logic [1:0]            idx_ff, idx_in;

   logic req_take, rsp_take, bund_done, bund_free, move;
   logic [kxb64_pkg::KEY_LEN_W-1:0] len_eff, pos_ext, pos_inc;
   logic [POS_W-1:0] pos_use;

   // ---------------- config writes ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         key_len_ff <= kxb64_pkg::KEY_LEN_W'(1);
      end else if (csr_wr_en && csr_index == kxb64_pkg::CSR_KEY_LENGTH) begin
         key_len_ff <= csr_wdata[kxb64_pkg::KEY_LEN_W-1:0];
      end
   end

   for (genvar g = 0; g < KEY_MAX; g++) begin : g_key
      localparam int LANE = g % 8;
      localparam kxb64_pkg::csr_index_type SEL =
         (g < 8) ? kxb64_pkg::CSR_KEY_LOW : kxb64_pkg::CSR_KEY_HIGH;
      always_ff @(posedge clock) begin
         if (reset) begin
            key_ff[g] <= 8'd0;
         end else if (csr_wr_en && csr_index == SEL) begin
            key_ff[g] <= csr_wdata[8*LANE +: 8];
         end
      end
   end

   // ---------------- key position ----------------
   // zero length acts as one, anything above the key size saturates
   always_comb begin
      if (key_len_ff == '0) begin
         len_eff = kxb64_pkg::KEY_LEN_W'(1);
      end else if (key_len_ff > KEY_MAX_L) begin
         len_eff = KEY_MAX_L;
      end else begin
         len_eff = key_len_ff;
      end
      // a length lowered under the position wraps it first
      pos_ext = kxb64_pkg::KEY_LEN_W'(pos_ff);
      pos_use = (pos_ext >= len_eff) ? '0 : pos_ff;
      pos_inc = kxb64_pkg::KEY_LEN_W'(pos_use) + kxb64_pkg::KEY_LEN_W'(1);
   end

   // ---------------- handshake ----------------
   assign rsp_valid  = bund_valid_ff;
   assign rsp_take   = bund_valid_ff && !rsp_stall;
   assign bund_done  = rsp_take && (idx_ff == bund_ff.last_idx);
   assign bund_free  = !bund_valid_ff || bund_done;
   assign move       = in_valid_ff && bund_free;
   assign req_stall  = in_valid_ff && !move;
   assign req_take   = req_valid && !req_stall;

   assign rsp_out_char  = bund_ff.chars[idx_ff];
   assign rsp_last_char = bund_ff.eom && (idx_ff == bund_ff.last_idx);

   // ---------------- encode ----------------
   kxb64_pkg::phase_type phase_enc;
   logic [3:0]           left_enc;

   kxb64_encode u_encode (
      .plain_byte (in_byte_ff),
      .key_byte   (key_ff[pos_use]),
      .eom        (in_eom_ff),
      .phase      (phase_ff),
      .left       (left_ff),
      .bundle     (bund_in),
      .phase_nxt  (phase_enc),
      .left_nxt   (left_enc)
   );

   always_comb begin
      in_valid_in   = in_valid_ff;
      bund_valid_in = bund_valid_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      phase_in      = phase_ff;
      left_in       = left_ff;
      if (move) begin
         in_valid_in   = 1'b0;
         bund_valid_in = 1'b1;
         idx_in        = 2'd0;
         phase_in      = phase_enc;
         left_in       = left_enc;
         if (in_eom_ff || pos_inc >= len_eff) begin
            pos_in = '0;
         end else begin
            pos_in = pos_inc[POS_W-1:0];
         end
      end else begin
         if (bund_done) begin
            bund_valid_in = 1'b0;
         end else if (rsp_take) begin
            idx_in = idx_ff + 2'd1;
         end
      end
      if (req_take) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         bund_valid_ff <= 1'b0;
         idx_ff        <= 2'd0;
         pos_ff        <= '0;
         phase_ff      <= kxb64_pkg::PH_0;
         left_ff       <= 4'd0;
      end else begin
         in_valid_ff   <= in_valid_in;
         bund_valid_ff <= bund_valid_in;
         idx_ff        <= idx_in;
         pos_ff        <= pos_in;
         phase_ff      <= phase_in;
         left_ff       <= left_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_data_byte;
         in_eom_ff  <= req_end_of_message;
      end
      if (move) begin
         bund_ff <= bund_in;
      end
   end

   // ---------------- assertions ----------------
   // the character pointer never runs past the byte's last character
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      bund_valid_ff |-> idx_ff <= bund_ff.last_idx)
      else $error("character index past end of bundle");

   // padding only appears on the final byte of a message
   a_pad_eom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_char == kxb64_pkg::PAD_CHAR |-> bund_ff.eom)
      else $error("padding outside end of message");

   // when the last character leaves, the encoder state is already cleared
   a_state_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_take && rsp_last_char |->
         phase_ff == kxb64_pkg::PH_0 && pos_ff == '0 && left_ff == 4'd0)
      else $error("encoder state not cleared at end of message");

endmodule

// ===== hw/rtl/kxb64_encode.sv =====
module kxb64_encode (
   input  logic [kxb64_pkg::BYTE_W-1:0] plain_byte,
   input  logic [kxb64_pkg::BYTE_W-1:0] key_byte,
   input  logic                         eom,
   input  kxb64_pkg::phase_type         phase,
   input  logic [3:0]                   left,
   output kxb64_pkg::bundle_type        bundle,
   output kxb64_pkg::phase_type         phase_nxt,
   output logic [3:0]                   left_nxt
);

   logic [kxb64_pkg::BYTE_W-1:0] b;

   assign b = plain_byte ^ key_byte;

   always_comb begin
      bundle.chars    = {kxb64_pkg::CHARS_MAX{kxb64_pkg::PAD_CHAR}};
      bundle.eom      = eom;
      bundle.last_idx = 2'd0;
      phase_nxt       = kxb64_pkg::PH_0;
      left_nxt        = 4'd0;
      unique case (phase)
         kxb64_pkg::PH_1: begin
            bundle.chars[0] = kxb64_pkg::b64_char({left[1:0], b[7:4]});
            left_nxt        = b[3:0];
            phase_nxt       = kxb64_pkg::PH_2;
            if (eom) begin
               bundle.chars[1] = kxb64_pkg::b64_char({b[3:0], 2'b00});
               bundle.last_idx = 2'd2;
            end
         end
         kxb64_pkg::PH_2: begin
            bundle.chars[0] = kxb64_pkg::b64_char({left, b[7:6]});
            bundle.chars[1] = kxb64_pkg::b64_char(b[5:0]);
            bundle.last_idx = 2'd1;
         end
         default: begin
            // group start; the unused phase code behaves the same
            bundle.chars[0] = kxb64_pkg::b64_char(b[7:2]);
            left_nxt        = {2'b00, b[1:0]};
            phase_nxt       = kxb64_pkg::PH_1;
            if (eom) begin
               bundle.chars[1] = kxb64_pkg::b64_char({b[1:0], 4'b0000});
               bundle.last_idx = 2'd3;
            end
         end
      endcase
      // end of message closes the group
      if (eom) begin
         phase_nxt = kxb64_pkg::PH_0;
         left_nxt  = 4'd0;
      end
   end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   localparam int KEY_BYTES   = 16;
   localparam int HOLD_CYCLES = 40;   // long receiver hold-off, fills the block
   localparam int DRAIN_TAIL  = 8;    // quiet cycles at the end to catch strays

   // Index 3 is decoded by nobody; writes to it must leave the key alone
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   // One character of the encoded stream as it should leave the block
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } encoded_char_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_end_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_char;
   logic        rsp_last_char;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = 2'd0;
   logic [63:0] csr_wdata = 64'h0;

   // Shadow of the key registers and of the encoder state
   logic [4:0]           key_len_reg  = 5'd1;
   logic [63:0]          key_low_reg  = 64'h0;
   logic [63:0]          key_high_reg = 64'h0;
   logic [3:0]           key_pos      = 4'd0;
   kxb64_pkg::phase_type group_phase  = kxb64_pkg::PH_0;
   logic [3:0]           carry_bits   = 4'd0;

   string b64_alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   encoded_char_type pending_chars[$];
   encoded_char_type head;

   int errors        = 0;
   int bytes_sent    = 0;
   int messages_done = 0;
   int chars_checked = 0;
   int key_settings  = 0;

   // Idle rates in percent; changed only between phases
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   logic hold_on = 1'b0;

   keyed_xor_base64_encoder #(
      .KEY_MAX(KEY_BYTES)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_char       (rsp_out_char),
      .rsp_last_char      (rsp_last_char),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------
   // Encoder prediction
   // ------------------------------------------------------------------

   function automatic logic [7:0] b64_symbol(input logic [5:0] v);
      return b64_alphabet[v];
   endfunction

   function automatic logic [7:0] key_at(input int unsigned idx);
      if (idx < 8)
         return key_low_reg[8*idx +: 8];
      return key_high_reg[8*(idx-8) +: 8];
   endfunction

   // XOR one byte with the running key and queue the base64 characters it
   // completes; on the end of a message also the flush and '=' padding.
   task automatic xor_encode_byte(input logic [7:0] data, input logic eom);
      int unsigned      len;
      int unsigned      pos;
      logic [7:0]       b;
      logic [7:0]       chars [0:3];
      int               n;
      int               k;
      encoded_char_type entry;
      n = 0;
      // zero length counts as one, anything above the key store saturates
      len = key_len_reg;
      if (len == 0)
         len = 1;
      if (len > KEY_BYTES)
         len = KEY_BYTES;
      // position left beyond a shortened key wraps to the start
      pos = key_pos;
      if (pos >= len)
         pos = 0;
      b = data ^ key_at(pos);
      pos++;
      key_pos = (pos >= len) ? 4'd0 : pos[3:0];

      case (group_phase)
         kxb64_pkg::PH_1: begin
            chars[n] = b64_symbol({carry_bits[1:0], b[7:4]});
            n++;
            carry_bits  = b[3:0];
            group_phase = kxb64_pkg::PH_2;
         end
         kxb64_pkg::PH_2: begin
            chars[n] = b64_symbol({carry_bits, b[7:6]});
            n++;
            chars[n] = b64_symbol(b[5:0]);
            n++;
            carry_bits  = 4'd0;
            group_phase = kxb64_pkg::PH_0;
         end
         default: begin
            chars[n] = b64_symbol(b[7:2]);
            n++;
            carry_bits  = {2'b00, b[1:0]};
            group_phase = kxb64_pkg::PH_1;
         end
      endcase

      if (eom) begin
         if (group_phase == kxb64_pkg::PH_1) begin
            chars[n] = b64_symbol({carry_bits[1:0], 4'b0000});
            chars[n+1] = kxb64_pkg::PAD_CHAR;
            chars[n+2] = kxb64_pkg::PAD_CHAR;
            n += 3;
         end else if (group_phase == kxb64_pkg::PH_2) begin
            chars[n] = b64_symbol({carry_bits, 2'b00});
            chars[n+1] = kxb64_pkg::PAD_CHAR;
            n += 2;
         end
         key_pos     = 4'd0;
         group_phase = kxb64_pkg::PH_0;
         carry_bits  = 4'd0;
         messages_done++;
      end

      for (k = 0; k < n; k++) begin
         entry.ch   = chars[k];
         entry.last = eom && (k == n - 1);
         pending_chars.push_back(entry);
      end
   endtask

   // ------------------------------------------------------------------
   // Response side: stall generation and character check
   // ------------------------------------------------------------------

   // hold_on wins over the random stall; both change only at clock edges
   always @(posedge clock) begin
      if (hold_on)
         rsp_stall <= 1'b1;
      else
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Every character transaction is matched against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_chars.size() == 0) begin
            $display("%0t: unexpected character %h last %b", $time, rsp_out_char,
                     rsp_last_char);
            errors++;
         end else begin
            head = pending_chars.pop_front();
            chars_checked++;
            if (rsp_out_char !== head.ch) begin
               $display("%0t: out_char mismatch: expected %h got %h", $time, head.ch,
                        rsp_out_char);
               errors++;
            end
            if (rsp_last_char !== head.last) begin
               $display("%0t: last_char mismatch: expected %b got %b", $time, head.last,
                        rsp_last_char);
               errors++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Request side and register helpers
   // ------------------------------------------------------------------

   // Offer one byte, optionally after a random gap, and wait for acceptance.
   // Valid is left high so back-to-back bytes need no second assignment.
   task automatic send_byte(input logic [7:0] data, input logic eom);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(99) < send_idle_pct);
      end
      req_valid          <= 1'b1;
      req_data_byte      <= data;
      req_end_of_message <= eom;
      do
         @(posedge clock);
      while (req_stall);
      xor_encode_byte(data, eom);
      bytes_sent++;
   endtask

   // Drop valid and wait until every expected character has come out
   task automatic finish_burst();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (pending_chars.size() != 0);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [63:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         kxb64_pkg::CSR_KEY_LENGTH: key_len_reg  = value[4:0];
         kxb64_pkg::CSR_KEY_LOW:    key_low_reg  = value;
         kxb64_pkg::CSR_KEY_HIGH:   key_high_reg = value;
         default: ;
      endcase
   endtask

   // Upper bits of the length word are random; only the low five count
   task automatic load_key(input logic [4:0] len, input logic [63:0] lo,
                           input logic [63:0] hi);
      csr_write(kxb64_pkg::CSR_KEY_LENGTH, {59'({$urandom, $urandom}), len});
      csr_write(kxb64_pkg::CSR_KEY_LOW, lo);
      csr_write(kxb64_pkg::CSR_KEY_HIGH, hi);
      csr_wr_en <= 1'b0;
      key_settings++;
   endtask

   function automatic logic [63:0] random_key_word();
      case ($urandom_range(5))
         0:       return 64'h0;
         1:       return {64{1'b1}};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic load_random_key();
      logic [4:0] len;
      case ($urandom_range(9))
         0:       len = 5'd0;
         1:       len = 5'($urandom_range(31, 17));
         2:       len = 5'd16;
         3:       len = 5'd1;
         default: len = 5'($urandom_range(16, 1));
      endcase
      load_key(len, random_key_word(), random_key_word());
      if ($urandom_range(3) == 0) begin
         csr_write(CSR_UNUSED, {$urandom, $urandom});
         csr_wr_en <= 1'b0;
      end
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct <= send_pct;
      recv_idle_pct <= recv_pct;
   endtask

   // Messages of random length and content; most short, some longer than
   // the key store. May stop inside a message so the next key write lands
   // mid-message.
   task automatic send_random_messages(input int n);
      int sent;
      int msg_len;
      int k;
      sent = 0;
      while (sent < n) begin
         msg_len = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
         for (k = 0; k < msg_len; k++)
            send_byte(8'($urandom_range(255)), k == msg_len - 1);
         sent += msg_len;
         // sender pause until the block has drained
         if ($urandom_range(11) == 0)
            finish_burst();
      end
      if ($urandom_range(1) == 1) begin
         msg_len = $urandom_range(5, 1);
         for (k = 0; k < msg_len; k++)
            send_byte(8'($urandom_range(255)), 1'b0);
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset key (length one, all zero): plain base64 with each padding case
   task automatic test_padding();
      send_byte(8'h00, 1'b1);                  // two '=' pads
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);                  // one '=' pad
      send_byte(8'hFB, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hBF, 1'b1);                  // no pad, '+' and '/'
      finish_burst();
   endtask

   task automatic test_key_settings();
      int k;
      // zero length behaves as a one-byte key
      load_key(5'd0, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
      send_byte(8'h55, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h0F, 1'b1);
      finish_burst();
      // oversized length saturates; stop mid-message with the position at 5
      load_key(5'd31, {64{1'b1}}, 64'h8040_2010_0804_0201);
      for (k = 0; k < 5; k++)
         send_byte(8'($urandom_range(255)), 1'b0);
      finish_burst();
      // shrink the key below the current position: position wraps to zero
      load_key(5'd3, 64'h00C3_5A7E, {64{1'b1}});
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      finish_burst();
   endtask

   task automatic test_ignored_index();
      csr_write(CSR_UNUSED, {64{1'b1}});
      csr_wr_en <= 1'b0;
      send_byte(8'h3C, 1'b1);
      finish_burst();
   endtask

   // Receiver holds off while bytes keep coming, so req_stall must rise;
   // then the sender waits for a full drain before one more message.
   task automatic test_backpressure();
      int k;
      set_idling(0, 0);
      load_key(5'd7, {$urandom, $urandom}, {$urandom, $urandom});
      fork
         begin
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_on <= 1'b0;
         end
         begin
            for (k = 0; k < 14; k++)
               send_byte(8'($urandom_range(255)), k == 13);
         end
      join
      finish_burst();
      for (k = 0; k < 5; k++)
         send_byte(8'($urandom_range(255)), k == 4);
      finish_burst();
   endtask

   task automatic test_random(input int send_pct, input int recv_pct, input int n);
      int part;
      set_idling(send_pct, recv_pct);
      for (part = 0; part < 3; part++) begin
         load_random_key();
         send_random_messages(n / 3);
         finish_burst();
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_padding();
      test_key_settings();
      test_ignored_index();
      test_backpressure();
      test_random(28, 45, 48);
      test_random(45, 28, 48);
      test_random(0, 0, 48);

      repeat (DRAIN_TAIL) @(posedge clock);
      if (pending_chars.size() != 0) begin
         $display("%0t: %0d expected characters never arrived", $time,
                  pending_chars.size());
         errors++;
      end

      $display("summary: %0d bytes in %0d messages, %0d characters checked, %0d keys",
               bytes_sent, messages_done, chars_checked, key_settings);
      $display("summary: all padding cases, key length limits, mid-message rekey, hold-off");
      if (errors == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #2000000;
      $display("testbench: FAIL");
      $finish;
   end

endmodule
